// File: hdl/three_wire_handshake_packet_link_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-wire handshake packet link
// Shared concurrent checks, sampled on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_HANDSHAKE_PACKET_LINK_MACROS_SVH
`define THREE_WIRE_HANDSHAKE_PACKET_LINK_MACROS_SVH

// Same-cycle implication, off while reset is high
`define TWH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define TWH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/twh_pkg.sv
// ----------------------------------------------------------------------------
// twh_pkg
// Types and constants shared by the handshake link front, back and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package twh_pkg;

   localparam int unsigned TX_DEPTH_DEF = 256;

   localparam logic [15:0] TIMEOUT_RST  = 16'd6667;
   localparam logic [7:0]  DEBOUNCE_RST = 8'd10;

   // Register indexes
   localparam logic REG_TIMEOUT  = 1'b0;
   localparam logic REG_DEBOUNCE = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_PUSH  = 2'd1,
      OP_SEND  = 2'd2,
      OP_RECV  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_SEND = 2'd1,
      MODE_RECV = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_LABEL  = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DATA   = 2'd2,
      PH_ACK    = 2'd3
   } phase_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_TMO1    = 3'd1;
   localparam logic [2:0] ST_TMO2    = 3'd2;
   localparam logic [2:0] ST_PARITY  = 3'd3;
   localparam logic [2:0] ST_NACK    = 3'd4;

   // One classified request
   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic [7:0] packet_label;
      logic [7:0] packet_length;
      logic       io1_level;
      logic       io2_level;
      logic       io3_level;
   } req_item_type;

   // One response
   typedef struct packed {
      logic [7:0] err_index;
      logic [2:0] err_bit;
      logic [1:0] err_phase;
      logic [2:0] status;
      logic       done_res;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       io3_drive;
      logic       io2_drive;
      logic       io1_drive;
   } rsp_item_type;

endpackage

// File: hdl/twh_front.sv
// ----------------------------------------------------------------------------
// twh_front
// Accepts requests, decodes the opcode and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module twh_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [31:0]           req_tdata,
   output logic                  q_valid,
   input  logic                  q_pop,
   output twh_pkg::req_item_type q_item
);
   import twh_pkg::*;

   req_item_type slot_ff [2];
   req_item_type slot_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;

   // Classify the incoming request
   always_comb begin
      slot_in.op            = op_type'(req_tuser);
      slot_in.data_byte     = req_tdata[7:0];
      slot_in.packet_label  = req_tdata[15:8];
      slot_in.packet_length = req_tdata[23:16];
      slot_in.io1_level     = req_tdata[24];
      slot_in.io2_level     = req_tdata[25];
      slot_in.io3_level     = req_tdata[26];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// File: hdl/twh_back.sv
// ----------------------------------------------------------------------------
// twh_back
// Link engine: runs the bit handshakes, keeps the transmit buffer and
// registers one response per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module twh_back #(
   parameter int unsigned TX_DEPTH = twh_pkg::TX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  twh_pkg::req_item_type q_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,
   output twh_pkg::rsp_item_type rsp_item
);
   import twh_pkg::*;

   localparam int unsigned AW = $clog2(TX_DEPTH);
   localparam logic [AW-1:0] PTR_LAST = AW'(TX_DEPTH - 1);

   // Configuration
   logic [15:0] timeout_ff;
   logic [7:0]  limit_ff;

   // Engine state
   mode_type   mode_ff, mode_in;
   logic       second_ff, second_in;
   phase_type  phase_ff, phase_in;
   logic [1:0] sub_ff, sub_in;
   logic [2:0] bc_ff, bc_in;
   logic [7:0] shift_ff, shift_in;
   logic       par_ff, par_in;
   logic       ack_ff, ack_in;
   logic [7:0] bi_ff, bi_in;
   logic [7:0] total_ff, total_in;
   logic [7:0] deb_ff, deb_in;
   logic [15:0] el_ff, el_in;
   logic [2:0] drive_ff, drive_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] ptr_ff, ptr_in;

   // Transmit buffer
   logic [7:0]    tx_mem [TX_DEPTH];
   logic [7:0]    rd_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] ptr_next;
   logic          mem_we;

   // Response
   logic          out_v_ff;
   rsp_item_type  out_ff, res;
   logic [1:0]    kind_ff, kind;

   // Scratch for the tick
   logic          tx, pin, hit, b, fin;
   logic [2:0]    fin_st, fin_bit;
   logic [1:0]    fin_ph;
   logic [7:0]    fin_ix, tot, bi_n;
   logic [15:0]   el_sat;

   assign q_pop    = q_valid && (!out_v_ff || rsp_tready);
   assign ptr_next = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
   assign rd_addr  = (phase_ff == PH_LENGTH) ? ptr_ff : ptr_next;

   // Next state of the engine for the popped request
   always_comb begin
      mode_in = mode_ff;   second_in = second_ff; phase_in = phase_ff;
      sub_in  = sub_ff;    bc_in = bc_ff;         shift_in = shift_ff;
      par_in  = par_ff;    ack_in = ack_ff;       bi_in = bi_ff;
      total_in = total_ff; deb_in = deb_ff;       el_in = el_ff;
      drive_in = drive_ff; fill_in = fill_ff;     ptr_in = ptr_ff;
      mem_we = 1'b0;
      res = '0;
      kind = 2'd0;
      fin = 1'b0; fin_st = ST_OK; fin_ph = 2'd0; fin_bit = 3'd0; fin_ix = 8'd0;
      hit = 1'b0; b = 1'b0; tot = total_ff; bi_n = bi_ff; el_sat = el_ff;
      if (mode_ff == MODE_SEND) begin
         tx = (phase_ff != PH_ACK) || (sub_ff == 2'd0);
      end else begin
         tx = (phase_ff == PH_ACK) && (sub_ff != 2'd0);
      end
      pin = tx ? q_item.io2_level : q_item.io3_level;

      if (q_pop) begin
         case (q_item.op)
            OP_TICK: begin
               if (mode_ff != MODE_IDLE) begin
                  // Debounce the watched wire
                  if (pin == second_ff) begin
                     if (deb_ff >= limit_ff) hit = 1'b1;
                     else deb_in = deb_ff + 8'd1;
                  end else begin
                     deb_in = 8'd0;
                  end
                  if (!hit) begin
                     el_sat = (el_ff == 16'hFFFF) ? el_ff : el_ff + 16'd1;
                     el_in  = el_sat;
                     if (el_sat >= timeout_ff) begin
                        fin    = 1'b1;
                        fin_st = (tx && second_ff) ? ST_TMO2 : ST_TMO1;
                        fin_ph = phase_ff;
                        fin_bit = (phase_ff == PH_ACK) ? {1'b0, sub_ff} : bc_ff;
                        fin_ix = (phase_ff == PH_DATA || phase_ff == PH_ACK) ? bi_ff : 8'd0;
                     end
                  end else begin
                     deb_in = 8'd0;
                     el_in  = 16'd0;
                     if (!second_ff) begin
                        // First edge: drive the bit or sample it
                        if (tx) begin
                           if (phase_ff != PH_ACK) b = shift_ff[0];
                           else if (mode_ff == MODE_RECV && sub_ff == 2'd1) b = ack_ff;
                           else b = par_ff;
                           if (phase_ff != PH_ACK) par_in = par_ff ^ b;
                           drive_in = {2'b01, b};
                        end else begin
                           shift_in = {q_item.io1_level, shift_ff[7:1]};
                           if (mode_ff == MODE_SEND && phase_ff == PH_ACK && sub_ff == 2'd1)
                              ack_in = q_item.io1_level;
                           drive_in = 3'b101;
                        end
                        second_in = 1'b1;
                     end else begin
                        // Second edge: release and finish the bit
                        drive_in  = 3'b111;
                        second_in = 1'b0;
                        if (tx) begin
                           if (phase_ff != PH_ACK) shift_in = {1'b0, shift_ff[7:1]};
                        end else begin
                           b = shift_ff[7];
                           if (mode_ff == MODE_RECV && (phase_ff != PH_ACK || sub_ff == 2'd0))
                              par_in = par_ff ^ b;
                           if (mode_ff == MODE_SEND && phase_ff == PH_ACK && sub_ff == 2'd2)
                              par_in = b;
                        end
                        if (phase_ff != PH_ACK) begin
                           bc_in = bc_ff + 3'd1;
                           if (bc_in == 3'd0) begin
                              if (mode_ff != MODE_SEND) begin
                                 kind = 2'(phase_ff) + 2'd1;
                                 res.rx_byte = shift_in;
                              end
                              if (phase_ff == PH_LABEL) begin
                                 phase_in = PH_LENGTH;
                                 if (mode_ff == MODE_SEND) shift_in = total_ff;
                              end else if (phase_ff == PH_LENGTH) begin
                                 if (mode_ff != MODE_SEND && shift_in < total_ff) tot = shift_in;
                                 total_in = tot;
                                 bi_in    = 8'd0;
                                 ptr_in   = '0;
                                 if (tot == 8'd0) begin
                                    fin = 1'b1;
                                 end else begin
                                    phase_in = PH_DATA;
                                    if (mode_ff == MODE_SEND) shift_in = rd_ff;
                                 end
                              end else begin
                                 phase_in = PH_ACK;
                                 sub_in   = 2'd0;
                              end
                           end
                        end else if (sub_ff == 2'd0) begin
                           sub_in = 2'd1;
                        end else if (sub_ff == 2'd1) begin
                           if (mode_ff != MODE_SEND) par_in = par_ff ^ 1'b1;
                           sub_in = 2'd2;
                        end else begin
                           // Close the ack exchange: finish or next byte
                           if (mode_ff == MODE_SEND && !par_in) begin
                              fin = 1'b1; fin_st = ST_PARITY; fin_ph = PH_ACK;
                              fin_bit = 3'd2; fin_ix = bi_ff;
                           end else if (mode_ff == MODE_SEND && !ack_ff) begin
                              par_in = 1'b0;
                              fin = 1'b1; fin_st = ST_NACK; fin_ph = PH_ACK;
                              fin_bit = 3'd1; fin_ix = bi_ff;
                           end else begin
                              par_in = 1'b0;
                              bi_n   = bi_ff + 8'd1;
                              bi_in  = bi_n;
                              ptr_in = ptr_next;
                              if (bi_n >= total_ff) begin
                                 fin = 1'b1;
                              end else begin
                                 phase_in = PH_DATA;
                                 sub_in   = 2'd0;
                                 if (mode_ff == MODE_SEND) shift_in = rd_ff;
                              end
                           end
                        end
                     end
                  end
               end
            end
            OP_PUSH: begin
               if (mode_ff != MODE_SEND) begin
                  mem_we  = 1'b1;
                  fill_in = (fill_ff == PTR_LAST) ? '0 : fill_ff + 1'b1;
               end
            end
            default: begin
               // Start a packet when idle
               if (mode_ff == MODE_IDLE) begin
                  mode_in  = (q_item.op == OP_SEND) ? MODE_SEND : MODE_RECV;
                  second_in = 1'b0; phase_in = PH_LABEL; sub_in = 2'd0;
                  bc_in    = 3'd0;
                  shift_in = (q_item.op == OP_SEND) ? q_item.packet_label : 8'd0;
                  par_in   = 1'b0; ack_in = 1'b1;
                  bi_in    = 8'd0; ptr_in = '0;
                  total_in = q_item.packet_length;
                  drive_in = 3'b111;
                  deb_in   = 8'd0; el_in = 16'd0;
                  if (q_item.op == OP_SEND) fill_in = '0;
               end
            end
         endcase
      end

      // End of packet
      if (fin) begin
         mode_in = MODE_IDLE; second_in = 1'b0; phase_in = PH_LABEL; sub_in = 2'd0;
         bc_in = 3'd0; drive_in = 3'b111; deb_in = 8'd0; el_in = 16'd0;
         res.done_res  = 1'b1;
         res.status    = fin_st;
         res.err_phase = fin_ph;
         res.err_bit   = fin_bit;
         res.err_index = fin_ix;
      end
      res.io1_drive = drive_in[0];
      res.io2_drive = drive_in[1];
      res.io3_drive = drive_in[2];
      res.busy_res  = (mode_in != MODE_IDLE);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         limit_ff   <= DEBOUNCE_RST;
         mode_ff    <= MODE_IDLE;
         second_ff  <= 1'b0;
         phase_ff   <= PH_LABEL;
         sub_ff     <= 2'd0;
         bc_ff      <= 3'd0;
         shift_ff   <= 8'd0;
         par_ff     <= 1'b0;
         ack_ff     <= 1'b1;
         bi_ff      <= 8'd0;
         total_ff   <= 8'd0;
         deb_ff     <= 8'd0;
         el_ff      <= 16'd0;
         drive_ff   <= 3'b111;
         fill_ff    <= '0;
         ptr_ff     <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_TIMEOUT)  timeout_ff <= csr_wdata;
         if (csr_we && csr_index == REG_DEBOUNCE) limit_ff   <= csr_wdata[7:0];
         mode_ff  <= mode_in;  second_ff <= second_in; phase_ff <= phase_in;
         sub_ff   <= sub_in;   bc_ff <= bc_in;         shift_ff <= shift_in;
         par_ff   <= par_in;   ack_ff <= ack_in;       bi_ff <= bi_in;
         total_ff <= total_in; deb_ff <= deb_in;       el_ff <= el_in;
         drive_ff <= drive_in; fill_ff <= fill_in;     ptr_ff <= ptr_in;
         if (q_pop)           out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff  <= res;
         kind_ff <= kind;
      end
   end

   // Transmit buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) tx_mem[fill_ff] <= q_item.data_byte;
      rd_ff <= tx_mem[rd_addr];
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_item   = out_ff;
   assign rsp_tuser  = kind_ff;

endmodule

// File: hdl/three_wire_handshake_packet_link.sv
// ----------------------------------------------------------------------------
// three_wire_handshake_packet_link
// Open-drain three-wire handshake link engine stepped by pin-sample requests.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | opcode in tuser, bytes and pin levels in tdata
//  rsp_    | out       | received-byte kind in tuser, drives and status in tdata
//  csr_    | in        | register writes, 0 timeout, 1 debounce limit
//
// One request per cycle while req_tready is high; each response is registered in the cycle
// after the engine pops its request, through a two-entry request queue and an output register.
// The engine loop updates all link state once for each popped request.
// The transmit buffer has a registered read port, prefetched one byte ahead.
// Reset is synchronous; the buffer itself is not cleared.
`timescale 1ns / 1ps
module three_wire_handshake_packet_link #(
   parameter int unsigned TX_DEPTH = twh_pkg::TX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // opcode
   input  logic [31:0] req_tdata,   // data_byte, packet_label, packet_length, io1..io3 level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // byte_kind
   output logic [31:0] rsp_tdata,   // io1..io3 drive, rx_byte, busy, done, status,
                                    // err_phase, err_bit, err_index
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import twh_pkg::*;
`include "three_wire_handshake_packet_link_macros.svh"

   logic         q_valid;
   logic         q_pop;
   req_item_type q_item;
   rsp_item_type rsp_item;

   twh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   twh_back #(.TX_DEPTH(TX_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {3'd0, rsp_item};

   `TWH_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_tvalid && rsp_item.done_res,
      !rsp_item.busy_res, "packet end left the link busy")
   `TWH_ASSERT_IMPLY(a_status_done, clock, reset,
      rsp_tvalid && rsp_item.status != ST_OK, rsp_item.done_res,
      "error status without packet end")
   `TWH_ASSERT_IMPLY(a_kind_active, clock, reset, rsp_tvalid && rsp_tuser != 2'd0,
      rsp_item.busy_res || rsp_item.done_res, "byte received outside a packet")
   `TWH_ASSERT_NEXT(a_pop_rsp, clock, reset, q_pop, rsp_tvalid,
      "engine step produced no response")

endmodule

// File: tb/three_wire_handshake_packet_link_tb.sv
// ----------------------------------------------------------------------------
// three_wire_handshake_packet_link_tb
// Self-checking bench for the three-wire handshake link engine. A partner
// process plays the far end of the wires from the predicted link state, so
// most packets run deep into the ack exchange. Noise, timeouts and busy-time
// starts and pushes are mixed in. Every response is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module three_wire_handshake_packet_link_tb;
   import twh_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;

   typedef struct {
      logic [1:0]   kind;
      rsp_item_type body;
   } link_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   three_wire_handshake_packet_link u_dut (.*);

   // Predicted link state
   logic [15:0] lk_timeout;
   logic [7:0]  lk_debounce;
   mode_type    lk_mode;
   logic [4:0]  lk_step;
   logic [2:0]  lk_bits;
   logic [7:0]  lk_shift;
   logic        lk_parity;
   logic        lk_ack;
   logic [7:0]  lk_index;
   logic [7:0]  lk_total;
   logic [7:0]  lk_deb_count;
   logic [15:0] lk_elapsed;
   logic [2:0]  lk_drive;
   logic [7:0]  lk_txbuf [256];
   logic [7:0]  lk_fill;
   link_result_type lk_res;

   link_result_type expected_results[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic void finish_packet(logic [2:0] st, logic [1:0] ph, logic [2:0] bt,
                                         logic [7:0] ix);
      lk_res.body.done_res  = 1'b1;
      lk_res.body.status    = st;
      lk_res.body.err_phase = ph;
      lk_res.body.err_bit   = bt;
      lk_res.body.err_index = ix;
      lk_mode     = MODE_IDLE;
      lk_step     = '0;
      lk_bits     = '0;
      lk_drive    = 3'b111;
      lk_deb_count = '0;
      lk_elapsed  = '0;
   endfunction

   function automatic logic link_transmits(logic [1:0] ph, logic [1:0] sub);
      if (lk_mode == MODE_SEND) return (ph != PH_ACK) || (sub == 2'd0);
      return (ph == PH_ACK) && (sub >= 2'd1);
   endfunction

   function automatic void advance_bit(logic [1:0] ph, logic [1:0] sub);
      logic sending;
      sending = (lk_mode == MODE_SEND);
      if (ph != PH_ACK) begin
         lk_bits = lk_bits + 3'd1;
         if (lk_bits != 0) return;
         if (!sending) begin
            lk_res.kind = ph + 2'd1;
            lk_res.body.rx_byte = lk_shift;
         end
         if (ph == PH_LABEL) begin
            lk_step = {2'd0, PH_LENGTH, 1'b0};
            if (sending) lk_shift = lk_total;
         end else if (ph == PH_LENGTH) begin
            if (!sending && lk_shift < lk_total) lk_total = lk_shift;
            lk_index = '0;
            if (lk_total == 0) begin
               finish_packet(ST_OK, 2'd0, 3'd0, 8'd0);
               return;
            end
            lk_step = {2'd0, PH_DATA, 1'b0};
            if (sending) lk_shift = lk_txbuf[lk_index];
         end else begin
            lk_step = {2'd0, PH_ACK, 1'b0};
         end
         return;
      end
      if (sub == 2'd0) begin
         lk_step = {2'd1, PH_ACK, 1'b0};
      end else if (sub == 2'd1) begin
         if (!sending) lk_parity = ~lk_parity;
         lk_step = {2'd2, PH_ACK, 1'b0};
      end else begin
         if (sending) begin
            if (lk_parity == 1'b0) begin
               finish_packet(ST_PARITY, PH_ACK, 3'd2, lk_index);
               return;
            end
            lk_parity = 1'b0;
            if (lk_ack == 1'b0) begin
               finish_packet(ST_NACK, PH_ACK, 3'd1, lk_index);
               return;
            end
         end else begin
            lk_parity = 1'b0;
         end
         lk_index = lk_index + 8'd1;
         if (lk_index >= lk_total) begin
            finish_packet(ST_OK, 2'd0, 3'd0, 8'd0);
            return;
         end
         lk_step = {2'd0, PH_DATA, 1'b0};
         if (sending) lk_shift = lk_txbuf[lk_index];
      end
   endfunction

   function automatic void sample_pins(logic io1, logic io2, logic io3);
      logic [1:0] ph;
      logic [1:0] sub;
      logic       second, tx, pin, hit, b;
      ph     = lk_step[2:1];
      sub    = lk_step[4:3];
      second = lk_step[0];
      tx     = link_transmits(ph, sub);
      pin    = tx ? io2 : io3;
      hit    = 1'b0;
      if (pin == second) begin
         if (lk_deb_count >= lk_debounce) hit = 1'b1;
         else lk_deb_count = lk_deb_count + 8'd1;
      end else begin
         lk_deb_count = '0;
      end
      if (!hit) begin
         if (lk_elapsed != 16'hFFFF) lk_elapsed = lk_elapsed + 16'd1;
         if (lk_elapsed >= lk_timeout)
            finish_packet((tx && second) ? ST_TMO2 : ST_TMO1, ph,
                          (ph == PH_ACK) ? {1'b0, sub} : lk_bits,
                          (ph >= PH_DATA) ? lk_index : 8'd0);
         return;
      end
      lk_deb_count = '0;
      lk_elapsed   = '0;
      if (!second) begin
         if (tx) begin
            if (ph != PH_ACK) b = lk_shift[0];
            else if (lk_mode == MODE_RECV && sub == 2'd1) b = lk_ack;
            else b = lk_parity;
            if (ph != PH_ACK) lk_parity = lk_parity ^ b;
            lk_drive = {2'b01, b};
         end else begin
            lk_shift = {io1, lk_shift[7:1]};
            if (lk_mode == MODE_SEND && ph == PH_ACK && sub == 2'd1) lk_ack = io1;
            lk_drive = 3'b101;
         end
         lk_step[0] = 1'b1;
      end else begin
         lk_drive = 3'b111;
         lk_step[0] = 1'b0;
         if (tx) begin
            if (ph != PH_ACK) lk_shift = lk_shift >> 1;
         end else begin
            b = lk_shift[7];
            if (lk_mode == MODE_RECV && (ph != PH_ACK || sub == 2'd0))
               lk_parity = lk_parity ^ b;
            if (lk_mode == MODE_SEND && ph == PH_ACK && sub == 2'd2) lk_parity = b;
         end
         advance_bit(ph, sub);
      end
   endfunction

   function automatic void open_packet(mode_type m, logic [7:0] first, logic [7:0] len);
      lk_mode = m;
      lk_step = '0;
      lk_bits = '0;
      lk_shift = first;
      lk_parity = 1'b0;
      lk_ack = 1'b1;
      lk_index = '0;
      lk_total = len;
      lk_drive = 3'b111;
      lk_deb_count = '0;
      lk_elapsed = '0;
   endfunction

   function automatic link_result_type predict_link(op_type op, logic [31:0] d);
      lk_res = '{kind: 2'd0, body: '0};
      case (op)
         OP_TICK: begin
            if (lk_mode != MODE_IDLE) sample_pins(d[24], d[25], d[26]);
         end
         OP_PUSH: begin
            if (lk_mode != MODE_SEND) begin
               lk_txbuf[lk_fill] = d[7:0];
               lk_fill = lk_fill + 8'd1;
            end
         end
         default: begin
            if (lk_mode == MODE_IDLE) begin
               if (op == OP_SEND) begin
                  lk_fill = '0;
                  open_packet(MODE_SEND, d[15:8], d[23:16]);
               end else begin
                  open_packet(MODE_RECV, 8'd0, d[23:16]);
               end
            end
         end
      endcase
      lk_res.body.io1_drive = lk_drive[0];
      lk_res.body.io2_drive = lk_drive[1];
      lk_res.body.io3_drive = lk_drive[2];
      lk_res.body.busy_res  = (lk_mode != MODE_IDLE);
      return lk_res;
   endfunction

   // ---------------- stimulus ----------------
   function automatic logic [31:0] pack_request(logic [7:0] data, logic [7:0] label,
                                                logic [7:0] len, logic [2:0] pins);
      return {5'd0, pins, len, label, data};
   endfunction

   // Drive one request, hold it until accepted, then predict its response
   task automatic send_request(op_type op, logic [31:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_link(op, d));
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Tick as the far end of the wires; noise_pct of ticks disagree with the wait
   task automatic partner_tick(int noise_pct);
      logic [2:0] pins;
      logic       want;
      pins = 3'($urandom_range(0, 7));
      want = lk_step[0];
      if ($urandom_range(0, 99) < noise_pct) want = ~want;
      if (link_transmits(lk_step[2:1], lk_step[4:3])) pins[1] = want;
      else pins[2] = want;
      send_request(OP_TICK, pack_request(8'($urandom), 8'($urandom), 8'($urandom), pins));
   endtask

   // Run the open packet to its end
   task automatic run_packet(int noise_pct);
      while (lk_mode != MODE_IDLE) partner_tick(noise_pct);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [15:0] value);
      drain_responses();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_TIMEOUT) lk_timeout = value;
      else lk_debounce = value[7:0];
   endtask

   // Fill the first transmit entries; no send ever carries more than four bytes
   task automatic test_fill_buffer();
      for (int i = 0; i < 8; i++)
         send_request(OP_PUSH, pack_request((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                                            8'($urandom), 8'($urandom), 3'($urandom)));
   endtask

   task automatic test_directed();
      write_register(REG_TIMEOUT, 16'd8);
      write_register(REG_DEBOUNCE, 16'd0);
      // tick while idle, all pins low then high
      send_request(OP_TICK, pack_request(8'h00, 8'h00, 8'h00, 3'b000));
      send_request(OP_TICK, pack_request(8'hFF, 8'hFF, 8'hFF, 3'b111));
      // receive with maximum 255, no strobe: first-wait timeout
      send_request(OP_RECV, pack_request(8'h00, 8'h00, 8'hFF, 3'b111));
      send_request(OP_SEND, pack_request(8'h00, 8'hFF, 8'hFF, 3'b000));   // ignored
      send_request(OP_RECV, pack_request(8'h00, 8'h00, 8'h00, 3'b000));   // ignored
      send_request(OP_PUSH, pack_request(8'hA5, 8'h00, 8'h00, 3'b000));   // written
      for (int i = 0; i < 8; i++)
         send_request(OP_TICK, pack_request(8'h00, 8'h00, 8'h00, 3'b111));
      // receive: strobe seen, then held low until the second wait times out
      send_request(OP_RECV, pack_request(8'h00, 8'h00, 8'h01, 3'b000));
      for (int i = 0; i < 9; i++)
         send_request(OP_TICK, pack_request(8'h00, 8'h00, 8'h00, 3'b011));
      // receive with maximum zero ends after the length byte
      send_request(OP_RECV, pack_request(8'h00, 8'h00, 8'h00, 3'b000));
      run_packet(0);
      // zero length send, push during it is dropped
      send_request(OP_SEND, pack_request(8'h00, 8'hFF, 8'h00, 3'b000));
      send_request(OP_PUSH, pack_request(8'h5A, 8'h00, 8'h00, 3'b000));
      run_packet(0);
   endtask

   // Random traffic: mostly complete packets, with noise and stray requests
   task automatic test_random_link(int count, int noise_pct);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (lk_mode == MODE_IDLE) begin
            if (r < 8)
               send_request(OP_PUSH, pack_request(8'($urandom), 8'($urandom), 8'($urandom),
                                                  3'($urandom)));
            else if (r < 14)
               send_request(OP_TICK, pack_request(8'($urandom), 8'($urandom), 8'($urandom),
                                                  3'($urandom)));
            else
               send_request((r < 57) ? OP_SEND : OP_RECV,
                            pack_request(8'($urandom), 8'($urandom),
                                         8'($urandom_range(0, 4)), 3'($urandom)));
         end else if (r < 3) begin
            send_request(OP_PUSH, pack_request(8'($urandom), 8'($urandom), 8'($urandom),
                                               3'($urandom)));
         end else if (r < 6) begin
            send_request(op_type'($urandom_range(2, 3)),
                         pack_request(8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom)));
         end else if (r < 9) begin
            send_request(OP_TICK, pack_request(8'($urandom), 8'($urandom), 8'($urandom),
                                               3'($urandom)));
         end else begin
            partner_tick(noise_pct);
         end
      end
   endtask

   // Short timeouts, first with the largest debounce so that waits fail on every edge
   task automatic test_timeouts();
      write_register(REG_DEBOUNCE, 16'd255);
      write_register(REG_TIMEOUT, 16'd1);
      test_random_link(30, 10);
      write_register(REG_TIMEOUT, 16'd5);
      write_register(REG_DEBOUNCE, 16'd1);
      test_random_link(60, 40);
   endtask

   // Receiver holds off while requests keep coming, then the sender waits
   task automatic test_backpressure();
      hold_off_requests++;
      test_random_link(40, 5);
      drain_responses();
      test_random_link(20, 5);
   endtask

   // ---------------- response side ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      end
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      link_result_type exp_r;
      rsp_item_type    act;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = rsp_item_type'(rsp_tdata[28:0]);
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual %h", $realtime,
                     rsp_tdata);
         end else begin
            exp_r = expected_results.pop_front();
            check_field("byte_kind", exp_r.kind, rsp_tuser);
            check_field("io1_drive", exp_r.body.io1_drive, act.io1_drive);
            check_field("io2_drive", exp_r.body.io2_drive, act.io2_drive);
            check_field("io3_drive", exp_r.body.io3_drive, act.io3_drive);
            check_field("rx_byte", exp_r.body.rx_byte, act.rx_byte);
            check_field("busy_res", exp_r.body.busy_res, act.busy_res);
            check_field("done_res", exp_r.body.done_res, act.done_res);
            check_field("status", exp_r.body.status, act.status);
            check_field("err_phase", exp_r.body.err_phase, act.err_phase);
            check_field("err_bit", exp_r.body.err_bit, act.err_bit);
            check_field("err_index", exp_r.body.err_index, act.err_index);
         end
      end
   end

   // Watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("three_wire_handshake_packet_link_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      lk_timeout = TIMEOUT_RST;
      lk_debounce = DEBOUNCE_RST;
      lk_fill = '0;
      open_packet(MODE_IDLE, 8'd0, 8'd0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 75;
      test_fill_buffer();
      test_directed();
      write_register(REG_TIMEOUT, 16'd65535);
      test_random_link(150, 10);

      send_idle_pct = 75;
      recv_idle_pct = 10;
      write_register(REG_TIMEOUT, 16'd40);
      write_register(REG_DEBOUNCE, 16'd2);
      test_random_link(150, 20);
      test_timeouts();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(REG_TIMEOUT, TIMEOUT_RST);
      write_register(REG_DEBOUNCE, 16'd0);
      test_random_link(100, 10);
      test_backpressure();

      drain_responses();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("three_wire_handshake_packet_link_tb passed");
      end else begin
         $display("three_wire_handshake_packet_link_tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/twh_pkg.sv
hdl/twh_front.sv
hdl/twh_back.sv
hdl/three_wire_handshake_packet_link.sv
tb/three_wire_handshake_packet_link_tb.sv
